// ===== hdl/tkit_pkg.sv =====
package tkit_pkg;

   localparam int LIST_LEN = 5;

   localparam int IDENT_W = 22;
   localparam int SCORE_W = 32;
   localparam int OP_W = 2;
   localparam int RANK_OUT_W = 3;

   // Entry count needs to hold LIST_LEN itself; the rank counter only indexes cells.
   localparam int FILL_W = $clog2(LIST_LEN + 1);
   localparam int RANK_W = (LIST_LEN > 1) ? $clog2(LIST_LEN) : 1;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ = 2'd2;

   typedef struct packed {
      logic [IDENT_W-1:0] ident;
      logic [SCORE_W-1:0] score;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic occupied;
      logic take_prev;
   } cell_ctl_type;

endpackage

// ===== hdl/tkit_req_if.sv =====
interface tkit_req_if import tkit_pkg::*; ;
   logic valid;
   logic ready;
   logic [OP_W-1:0] op;
   logic [IDENT_W-1:0] ident;
   logic [SCORE_W-1:0] score;

   modport source (output valid, output op, output ident, output score, input ready);
   modport sink (input valid, input op, input ident, input score, output ready);
endinterface

// ===== hdl/tkit_rsp_if.sv =====
interface tkit_rsp_if import tkit_pkg::*; ;
   logic valid;
   logic ready;
   logic [IDENT_W-1:0] out_ident;
   logic [SCORE_W-1:0] out_score;
   logic [RANK_OUT_W-1:0] rank;
   logic last;

   modport source (output valid, output out_ident, output out_score, output rank,
                   output last, input ready);
   modport sink (input valid, input out_ident, input out_score, input rank,
                 input last, output ready);
endinterface

// ===== hdl/tkit_cell.sv =====
module tkit_cell import tkit_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  entry_type    cand,
   input  entry_type    prev_entry,
   output logic         take,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // A cell gives way when it is empty or the candidate strictly beats it.
   assign take = !ctl.occupied || (cand.score > entry_ff.score);
   assign entry = entry_ff;

   // If the upper neighbor also gives way, this cell takes the neighbor's entry;
   // otherwise this is the insertion point and the candidate lands here.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert && take) begin
         entry_in = ctl.take_prev ? prev_entry : cand;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hdl/top_k_insertion_tracker.sv =====
// Top-K tracker: keeps the LIST_LEN largest candidates (identifier plus unsigned
// score) in descending score order, in a row of compare-and-shift cells.
// The req channel carries one command word: insert, clear or read out.
// Insert and clear words are taken one per cycle while no read-out is running,
// and take effect at the edge where they are accepted; every cell compares
// against the candidate at once. On a full list a candidate enters only if
// it strictly beats the smallest entry, and equal scores rank after old ones.
// A read-out word of a list holding n entries produces n rsp words, rank 0
// first, with last set on the final one; an empty list produces no word.
// An accepted read-out goes to the state register first; the sequencer then
// loads one rsp word per cycle into the output register while rsp.ready is
// high. req.ready stays low while the read-out sequencer walks the ranks, until
// the last word is loaded, stalls included. When rsp.ready is low the pending
// word is held in the output register and the sequencer waits.
// Synchronous reset empties the list, idles the sequencer and drops rsp.valid.
module top_k_insertion_tracker import tkit_pkg::*; (
   input logic        clock,
   input logic        reset,
   tkit_req_if.sink   req,
   tkit_rsp_if.source rsp
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [RANK_W-1:0] cnt_ff, cnt_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_last_ff, rsp_last_in;
   logic [IDENT_W-1:0] rsp_ident_ff, rsp_ident_in;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic [RANK_OUT_W-1:0] rsp_rank_ff, rsp_rank_in;

   logic req_accept;
   logic do_insert;
   logic word_load;
   logic word_last;

   entry_type cand;
   entry_type cell_entry [LIST_LEN];
   logic [LIST_LEN-1:0] cell_take;
   cell_ctl_type cell_ctl [LIST_LEN];

   assign req.ready = (state_ff == ST_IDLE);
   assign req_accept = req.valid && req.ready;
   assign do_insert = req_accept && (req.op == OP_INSERT);

   assign cand.ident = req.ident;
   assign cand.score = req.score;

   // The chain of cells. Cell 0 is rank 0; each cell sees whether its upper
   // neighbor gives way and takes that neighbor's entry when it does.
   for (genvar i = 0; i < LIST_LEN; i++) begin : g_cell
      assign cell_ctl[i].insert = do_insert;
      assign cell_ctl[i].occupied = (FILL_W'(i) < fill_ff);
      if (i == 0) begin : g_head
         assign cell_ctl[i].take_prev = 1'b0;
         tkit_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl[i]),
            .cand       (cand),
            .prev_entry (cand),
            .take       (cell_take[i]),
            .entry      (cell_entry[i])
         );
      end else begin : g_body
         assign cell_ctl[i].take_prev = cell_take[i-1];
         tkit_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl[i]),
            .cand       (cand),
            .prev_entry (cell_entry[i-1]),
            .take       (cell_take[i]),
            .entry      (cell_entry[i])
         );
      end
   end

   // The output register is free when empty or being drained this cycle.
   assign word_load = (state_ff == ST_READ) && (!rsp_valid_ff || rsp.ready);
   assign word_last = ((FILL_W'(cnt_ff) + FILL_W'(1)) == fill_ff);

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      cnt_in = cnt_ff;
      if (req_accept) begin
         unique case (req.op)
            OP_INSERT: begin
               if (fill_ff < FILL_W'(LIST_LEN)) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
            end
            OP_CLEAR: begin
               fill_in = '0;
            end
            OP_READ: begin
               if (fill_ff != '0) begin
                  state_in = ST_READ;
                  cnt_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
      if (word_load) begin
         if (word_last) begin
            state_in = ST_IDLE;
         end else begin
            cnt_in = cnt_ff + RANK_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in = rsp_last_ff;
      rsp_ident_in = rsp_ident_ff;
      rsp_score_in = rsp_score_ff;
      rsp_rank_in = rsp_rank_ff;
      if (word_load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in = word_last;
         rsp_ident_in = cell_entry[cnt_ff].ident;
         rsp_score_in = cell_entry[cnt_ff].score;
         rsp_rank_in = RANK_OUT_W'(cnt_ff);
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_last_ff <= rsp_last_in;
      rsp_ident_ff <= rsp_ident_in;
      rsp_score_ff <= rsp_score_in;
      rsp_rank_ff <= rsp_rank_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.last = rsp_last_ff;
   assign rsp.out_ident = rsp_ident_ff;
   assign rsp.out_score = rsp_score_ff;
   assign rsp.rank = rsp_rank_ff;

`ifndef NO_ASSERTIONS
   logic [LIST_LEN-1:0] order_ok;

   always_comb begin
      order_ok[0] = 1'b1;
      for (int i = 1; i < LIST_LEN; i++) begin
         order_ok[i] = !cell_ctl[i].occupied ||
                       (cell_entry[i-1].score >= cell_entry[i].score);
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(LIST_LEN))
      else $error("entry count exceeds list length");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      &order_ok)
      else $error("occupied cells out of descending order");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req.op == OP_CLEAR) |=> fill_ff == '0)
      else $error("clear did not empty the list");

   a_read_start: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req.op == OP_READ) && (fill_ff != '0) |=> state_ff == ST_READ)
      else $error("read-out of a non-empty list did not start");
`endif

endmodule
